// ===== sv/ttv_pkg.sv =====
package ttv_pkg;

    // Field widths
    localparam int COMP_W  = 16;
    localparam int VEC_W   = 48;
    localparam int TC_W    = 32;

    // Datapath widths
    localparam int DIFF_W      = 17;   // edge and texcoord differences
    localparam int PROD_W      = 33;   // normal * edge
    localparam int CROSS_W     = 34;   // du * dv
    localparam int DOT_W       = 35;   // normal . edge
    localparam int PPROD_W     = 51;   // dot * normal
    localparam int RND_SH      = 22;   // Q.36 -> Q.14
    localparam int PROJ_W      = 30;   // projected edge component, Q.14
    localparam int TERM_W      = 47;   // du * projected component
    localparam int T_W         = 48;   // tangent component, Q.26
    localparam int NORM_STAGES = 6;    // shift by 32,16,8,4,2,1
    localparam int MAG_W       = 30;   // normalized magnitude
    localparam int SQ_W        = 60;
    localparam int SUMSQ_W     = 62;
    localparam int ROOT_W      = 31;
    localparam int QUO_W       = 15;   // quotient up to 16384
    localparam int FRAC_SH     = 14;   // times 16384
    localparam int NUM_W       = MAG_W + FRAC_SH + 1;

    // Sideband carried through the divider
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } t_sign;

    // One result item
    typedef struct packed {
        logic signed [COMP_W-1:0] tx;
        logic signed [COMP_W-1:0] ty;
        logic signed [COMP_W-1:0] tz;
        logic                     degen;
    } t_result;

endpackage

// ===== sv/ttv_in_if.sv =====
interface ttv_in_if;
    import ttv_pkg::*;

    logic               valid;
    logic               ready;
    logic [VEC_W-1:0]   corner_position;
    logic [VEC_W-1:0]   first_neighbour_position;
    logic [VEC_W-1:0]   second_neighbour_position;
    logic [VEC_W-1:0]   corner_normal;
    logic [TC_W-1:0]    corner_texcoord;
    logic [TC_W-1:0]    first_neighbour_texcoord;
    logic [TC_W-1:0]    second_neighbour_texcoord;

    modport source (
        output valid, corner_position, first_neighbour_position,
               second_neighbour_position, corner_normal, corner_texcoord,
               first_neighbour_texcoord, second_neighbour_texcoord,
        input  ready
    );

    modport sink (
        input  valid, corner_position, first_neighbour_position,
               second_neighbour_position, corner_normal, corner_texcoord,
               first_neighbour_texcoord, second_neighbour_texcoord,
        output ready
    );
endinterface

// ===== sv/ttv_out_if.sv =====
interface ttv_out_if;
    import ttv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] tangent_x;
    logic signed [COMP_W-1:0] tangent_y;
    logic signed [COMP_W-1:0] tangent_z;
    logic                     degenerate;

    modport source (
        output valid, tangent_x, tangent_y, tangent_z, degenerate,
        input  ready
    );

    modport sink (
        input  valid, tangent_x, tangent_y, tangent_z, degenerate,
        output ready
    );
endinterface

// ===== sv/triangle_tangent_vector.sv =====
// Throughput: one item per cycle while the skid stage is empty; the 31-stage square root and
// the 16-stage divider are fully pipelined, so no unit is shared between items.
// A two-entry output register and skid stage keep input ready while a result waits.
// Reset (synchronous, active low) clears all valid bits; the datapath registers are not reset.
module triangle_tangent_vector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttv_in_if.sink     i_in,
    ttv_out_if.source  o_out
);
    import ttv_pkg::*;

    localparam int ISQ_SIDE_W = 3 * MAG_W + 4;
    localparam int DIV_SIDE_W = 4;
    localparam logic signed [PPROD_W-1:0] HALF_LSB = PPROD_W'(1) << (RND_SH - 1);

    logic en;
    logic r_skid_v;

    // Whole pipeline advances unless the skid stage is occupied
    assign en         = !r_skid_v;
    assign i_in.ready = en;

    // Stage 1: edge and texcoord differences
    logic                     r1_v;
    logic signed [DIFF_W-1:0] r1_ab [3];
    logic signed [DIFF_W-1:0] r1_ac [3];
    logic signed [COMP_W-1:0] r1_n  [3];
    logic signed [DIFF_W-1:0] r1_du_ab, r1_du_ac, r1_dv_ab, r1_dv_ac;

    function automatic logic signed [DIFF_W-1:0] sub16(input logic [COMP_W-1:0] x,
                                                       input logic [COMP_W-1:0] y);
        return $signed({x[COMP_W-1], x}) - $signed({y[COMP_W-1], y});
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_ab[i] <= sub16(i_in.first_neighbour_position[16*i +: 16],
                                  i_in.corner_position[16*i +: 16]);
                r1_ac[i] <= sub16(i_in.second_neighbour_position[16*i +: 16],
                                  i_in.corner_position[16*i +: 16]);
                r1_n[i]  <= $signed(i_in.corner_normal[16*i +: 16]);
            end
            r1_du_ab <= sub16(i_in.first_neighbour_texcoord[15:0], i_in.corner_texcoord[15:0]);
            r1_du_ac <= sub16(i_in.second_neighbour_texcoord[15:0], i_in.corner_texcoord[15:0]);
            r1_dv_ab <= sub16(i_in.first_neighbour_texcoord[31:16],
                              i_in.corner_texcoord[31:16]);
            r1_dv_ac <= sub16(i_in.second_neighbour_texcoord[31:16],
                              i_in.corner_texcoord[31:16]);
        end
    end

    // Stage 2: normal-edge products and the winding cross products
    logic                      r2_v;
    logic signed [PROD_W-1:0]  r2_nab [3];
    logic signed [PROD_W-1:0]  r2_nac [3];
    logic signed [DIFF_W-1:0]  r2_ab  [3];
    logic signed [DIFF_W-1:0]  r2_ac  [3];
    logic signed [COMP_W-1:0]  r2_n   [3];
    logic signed [CROSS_W-1:0] r2_cross_a, r2_cross_b;
    logic signed [DIFF_W-1:0]  r2_du_ab, r2_du_ac;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_nab[i] <= r1_n[i] * r1_ab[i];
                r2_nac[i] <= r1_n[i] * r1_ac[i];
                r2_ab[i]  <= r1_ab[i];
                r2_ac[i]  <= r1_ac[i];
                r2_n[i]   <= r1_n[i];
            end
            r2_cross_a <= r1_du_ac * r1_dv_ab;
            r2_cross_b <= r1_du_ab * r1_dv_ac;
            r2_du_ab   <= r1_du_ab;
            r2_du_ac   <= r1_du_ac;
        end
    end

    // Stage 3: dot products; flip u differences on reversed winding
    logic                     r3_v;
    logic signed [DOT_W-1:0]  r3_dot_ab, r3_dot_ac;
    logic signed [DIFF_W-1:0] r3_ab [3];
    logic signed [DIFF_W-1:0] r3_ac [3];
    logic signed [COMP_W-1:0] r3_n  [3];
    logic signed [DIFF_W-1:0] r3_du_ab, r3_du_ac;
    logic                     flip;

    assign flip = r2_cross_a > r2_cross_b;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dot_ab <= DOT_W'(r2_nab[0]) + DOT_W'(r2_nab[1]) + DOT_W'(r2_nab[2]);
            r3_dot_ac <= DOT_W'(r2_nac[0]) + DOT_W'(r2_nac[1]) + DOT_W'(r2_nac[2]);
            for (int i = 0; i < 3; i++) begin
                r3_ab[i] <= r2_ab[i];
                r3_ac[i] <= r2_ac[i];
                r3_n[i]  <= r2_n[i];
            end
            r3_du_ab <= flip ? -r2_du_ab : r2_du_ab;
            r3_du_ac <= flip ? -r2_du_ac : r2_du_ac;
        end
    end

    // Stage 4: normal component of each edge
    logic                      r4_v;
    logic signed [PPROD_W-1:0] r4_pab [3];
    logic signed [PPROD_W-1:0] r4_pac [3];
    logic signed [DIFF_W-1:0]  r4_ab  [3];
    logic signed [DIFF_W-1:0]  r4_ac  [3];
    logic signed [DIFF_W-1:0]  r4_du_ab, r4_du_ac;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r4_pab[i] <= r3_dot_ab * r3_n[i];
                r4_pac[i] <= r3_dot_ac * r3_n[i];
                r4_ab[i]  <= r3_ab[i];
                r4_ac[i]  <= r3_ac[i];
            end
            r4_du_ab <= r3_du_ab;
            r4_du_ac <= r3_du_ac;
        end
    end

    // Stage 5: projected edges, normal part rounded half up to Q.14
    logic                      r5_v;
    logic signed [PROJ_W-1:0]  r5_pab [3];
    logic signed [PROJ_W-1:0]  r5_pac [3];
    logic signed [DIFF_W-1:0]  r5_du_ab, r5_du_ac;
    logic signed [PROJ_W-1:0]  n5_pab [3];
    logic signed [PROJ_W-1:0]  n5_pac [3];

    always_comb begin
        logic signed [PPROD_W-1:0] sum_ab;
        logic signed [PPROD_W-1:0] sum_ac;
        for (int i = 0; i < 3; i++) begin
            sum_ab    = r4_pab[i] + HALF_LSB;
            sum_ac    = r4_pac[i] + HALF_LSB;
            n5_pab[i] = PROJ_W'($signed({r4_ab[i], 6'b0}))
                      - PROJ_W'($signed(sum_ab[PPROD_W-1:RND_SH]));
            n5_pac[i] = PROJ_W'($signed({r4_ac[i], 6'b0}))
                      - PROJ_W'($signed(sum_ac[PPROD_W-1:RND_SH]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r5_pab[i] <= n5_pab[i];
                r5_pac[i] <= n5_pac[i];
            end
            r5_du_ab <= r4_du_ab;
            r5_du_ac <= r4_du_ac;
        end
    end

    // Stage 6: tangent terms
    logic                     r6_v;
    logic signed [TERM_W-1:0] r6_ta [3];
    logic signed [TERM_W-1:0] r6_tb [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r6_ta[i] <= r5_du_ac * r5_pab[i];
                r6_tb[i] <= r5_du_ab * r5_pac[i];
            end
        end
    end

    // Stage 7: tangent, Q.26
    logic                  r7_v;
    logic signed [T_W-1:0] r7_t [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r7_t[i] <= T_W'(r6_ta[i]) - T_W'(r6_tb[i]);
            end
        end
    end

    // Stage 8: sign and magnitude
    logic                  r8_v;
    logic [2:0]            r8_neg;
    logic [2:0][T_W-1:0]   r8_mag;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r8_neg[i] <= r7_t[i][T_W-1];
                r8_mag[i] <= r7_t[i][T_W-1] ? $unsigned(-r7_t[i]) : $unsigned(r7_t[i]);
            end
        end
    end

    // Stage 9: largest magnitude
    logic                  r9_v;
    logic [T_W-1:0]        r9_m;
    logic [2:0]            r9_neg;
    logic [2:0][T_W-1:0]   r9_mag;
    logic [T_W-1:0]        n9_m01;

    assign n9_m01 = (r8_mag[1] > r8_mag[0]) ? r8_mag[1] : r8_mag[0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_m   <= (r8_mag[2] > n9_m01) ? r8_mag[2] : n9_m01;
            r9_neg <= r8_neg;
            r9_mag <= r8_mag;
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    // Normalizing shifter: left shifts by 32,16,8,4,2,1 until the largest
    // magnitude has its top bit set
    logic                s_nv   [NORM_STAGES+1];
    logic [T_W-1:0]      s_nm   [NORM_STAGES+1];
    logic [2:0][T_W-1:0] s_nmag [NORM_STAGES+1];
    logic [2:0]          s_nneg [NORM_STAGES+1];
    logic                s_ndeg [NORM_STAGES+1];

    assign s_nv[0]   = r9_v;
    assign s_nm[0]   = r9_m;
    assign s_nmag[0] = r9_mag;
    assign s_nneg[0] = r9_neg;
    assign s_ndeg[0] = (r9_m == '0);

    genvar g;
    generate
        for (g = 0; g < NORM_STAGES; g++) begin : g_norm
            localparam int SH = (1 << (NORM_STAGES - 1)) >> g;

            logic                r_v;
            logic [T_W-1:0]      r_m;
            logic [2:0][T_W-1:0] r_mag;
            logic [2:0]          r_neg;
            logic                r_deg;
            logic                top_zero;

            assign top_zero = (s_nm[g][T_W-1 -: SH] == '0);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (en) begin
                    r_v <= s_nv[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_m <= top_zero ? s_nm[g] << SH : s_nm[g];
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= top_zero ? s_nmag[g][i] << SH : s_nmag[g][i];
                    end
                    r_neg <= s_nneg[g];
                    r_deg <= s_ndeg[g];
                end
            end

            assign s_nv[g+1]   = r_v;
            assign s_nm[g+1]   = r_m;
            assign s_nmag[g+1] = r_mag;
            assign s_nneg[g+1] = r_neg;
            assign s_ndeg[g+1] = r_deg;
        end
    endgenerate

    // Squares of the normalized magnitudes
    logic                  r_sq_v;
    logic [2:0][SQ_W-1:0]  r_sq;
    logic [2:0][MAG_W-1:0] r_sq_mag;
    logic [2:0]            r_sq_neg;
    logic                  r_sq_deg;
    logic [2:0][MAG_W-1:0] nmag;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nmag[i] = s_nmag[NORM_STAGES][i][T_W-1 -: MAG_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SQ_W'(nmag[i]) * SQ_W'(nmag[i]);
            end
            r_sq_mag <= nmag;
            r_sq_neg <= s_nneg[NORM_STAGES];
            r_sq_deg <= s_ndeg[NORM_STAGES];
        end
    end

    // Sum of squares
    logic                  r_sum_v;
    logic [SUMSQ_W-1:0]    r_sum;
    logic [2:0][MAG_W-1:0] r_sum_mag;
    t_sign                 r_sum_sign;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum      <= SUMSQ_W'(r_sq[0]) + SUMSQ_W'(r_sq[1]) + SUMSQ_W'(r_sq[2]);
            r_sum_mag  <= r_sq_mag;
            r_sum_sign <= '{neg: r_sq_neg, degen: r_sq_deg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v  <= 1'b0;
            r_sum_v <= 1'b0;
        end else if (en) begin
            r_sq_v  <= s_nv[NORM_STAGES];
            r_sum_v <= r_sq_v;
        end
    end

    // Vector length
    logic                  sq_v;
    logic [ROOT_W-1:0]     sq_root;
    logic [ISQ_SIDE_W-1:0] sq_side;
    logic [2:0][MAG_W-1:0] sq_mag;
    t_sign                 sq_sign;

    ttv_isqrt #(
        .SIDE_W (ISQ_SIDE_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_sum_v),
        .i_radicand (r_sum),
        .i_side     ({r_sum_mag, r_sum_sign}),
        .o_valid    (sq_v),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    assign {sq_mag, sq_sign} = sq_side;

    // Rounded quotients mag * 16384 / L
    logic                  dv_v;
    logic [2:0][QUO_W-1:0] dv_quo;
    t_sign                 dv_sign;

    ttv_div #(
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (sq_v),
        .i_divisor (sq_root),
        .i_mag     (sq_mag),
        .i_side    (sq_sign),
        .o_valid   (dv_v),
        .o_quo     (dv_quo),
        .o_side    (dv_sign)
    );

    // Apply signs; a zero tangent gives a zero vector
    t_result                  res;
    logic signed [COMP_W-1:0] comp [3];

    always_comb begin
        logic signed [COMP_W-1:0] q;
        for (int i = 0; i < 3; i++) begin
            q       = $signed({1'b0, dv_quo[i]});
            comp[i] = dv_sign.degen ? '0 : (dv_sign.neg[i] ? -q : q);
        end
        res = '{tx: comp[0], ty: comp[1], tz: comp[2], degen: dv_sign.degen};
    end

    // Output register with skid stage
    logic    r_out_v;
    t_result r_out;
    t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_out.ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= dv_v;
            end
        end else if (dv_v && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_out.ready) begin
            r_out <= r_skid_v ? r_skid : res;
        end
        if (r_out_v && !o_out.ready && !r_skid_v) begin
            r_skid <= res;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.tangent_x  = r_out.tx;
    assign o_out.tangent_y  = r_out.ty;
    assign o_out.tangent_z  = r_out.tz;
    assign o_out.degenerate = r_out.degen;

endmodule

// ===== sv/ttv_isqrt.sv =====
module ttv_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [ttv_pkg::SUMSQ_W-1:0]  i_radicand,
    input  logic [SIDE_W-1:0]            i_side,
    output logic                         o_valid,
    output logic [ttv_pkg::ROOT_W-1:0]   o_root,
    output logic [SIDE_W-1:0]            o_side
);
    import ttv_pkg::*;

    // One result bit per stage, restoring square root
    localparam int STEPS = ROOT_W;

    logic               s_v    [STEPS+1];
    logic [SUMSQ_W-1:0] s_rem  [STEPS+1];
    logic [SUMSQ_W-1:0] s_res  [STEPS+1];
    logic [SIDE_W-1:0]  s_side [STEPS+1];

    assign s_v[0]    = i_valid;
    assign s_rem[0]  = i_radicand;
    assign s_res[0]  = '0;
    assign s_side[0] = i_side;

    genvar g;
    generate
        for (g = 0; g < STEPS; g++) begin : g_step
            localparam logic [SUMSQ_W-1:0] BIT = SUMSQ_W'(1) << (2 * (STEPS - 1 - g));

            logic               r_v;
            logic [SUMSQ_W-1:0] r_rem;
            logic [SUMSQ_W-1:0] r_res;
            logic [SIDE_W-1:0]  r_side;
            logic [SUMSQ_W-1:0] trial;
            logic               fits;
            logic [SUMSQ_W-1:0] n_rem;
            logic [SUMSQ_W-1:0] n_res;

            // Trial subtract of the next root bit
            always_comb begin
                trial = s_res[g] + BIT;
                fits  = s_rem[g] >= trial;
                n_rem = fits ? s_rem[g] - trial : s_rem[g];
                n_res = fits ? (s_res[g] >> 1) + BIT : s_res[g] >> 1;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_en) begin
                    r_v <= s_v[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem  <= n_rem;
                    r_res  <= n_res;
                    r_side <= s_side[g];
                end
            end

            assign s_v[g+1]    = r_v;
            assign s_rem[g+1]  = r_rem;
            assign s_res[g+1]  = r_res;
            assign s_side[g+1] = r_side;
        end
    endgenerate

    assign o_valid = s_v[STEPS];
    assign o_root  = s_res[STEPS][ROOT_W-1:0];
    assign o_side  = s_side[STEPS];

endmodule

// ===== sv/ttv_div.sv =====
module ttv_div #(
    parameter int SIDE_W = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [ttv_pkg::ROOT_W-1:0]          i_divisor,
    input  logic [2:0][ttv_pkg::MAG_W-1:0]      i_mag,
    input  logic [SIDE_W-1:0]                   i_side,
    output logic                                o_valid,
    output logic [2:0][ttv_pkg::QUO_W-1:0]      o_quo,
    output logic [SIDE_W-1:0]                   o_side
);
    import ttv_pkg::*;

    // Setup stage: numerator = mag * 16384 + floor(L / 2)
    logic                       r_v0;
    logic [ROOT_W-1:0]          r_d0;
    logic [2:0][NUM_W-1:0]      r_rem0;
    logic [SIDE_W-1:0]          r_side0;
    logic [2:0][NUM_W-1:0]      n_rem0;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rem0[i] = {1'b0, i_mag[i], {FRAC_SH{1'b0}}}
                      + NUM_W'(i_divisor >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d0    <= i_divisor;
            r_rem0  <= n_rem0;
            r_side0 <= i_side;
        end
    end

    // Restoring division, one quotient bit per stage for all three lanes
    logic                   s_v    [QUO_W+1];
    logic [ROOT_W-1:0]      s_d    [QUO_W+1];
    logic [2:0][NUM_W-1:0]  s_rem  [QUO_W+1];
    logic [2:0][QUO_W-1:0]  s_quo  [QUO_W+1];
    logic [SIDE_W-1:0]      s_side [QUO_W+1];

    assign s_v[0]    = r_v0;
    assign s_d[0]    = r_d0;
    assign s_rem[0]  = r_rem0;
    assign s_quo[0]  = '0;
    assign s_side[0] = r_side0;

    genvar g;
    generate
        for (g = 0; g < QUO_W; g++) begin : g_bit
            localparam int SH = QUO_W - 1 - g;

            logic                   r_v;
            logic [ROOT_W-1:0]      r_d;
            logic [2:0][NUM_W-1:0]  r_rem;
            logic [2:0][QUO_W-1:0]  r_quo;
            logic [SIDE_W-1:0]      r_side;
            logic [NUM_W-1:0]       dsh;
            logic [2:0][NUM_W-1:0]  n_rem;
            logic [2:0][QUO_W-1:0]  n_quo;
            logic [2:0]             fits;

            always_comb begin
                dsh = NUM_W'(s_d[g]) << SH;
                for (int i = 0; i < 3; i++) begin
                    fits[i]  = s_rem[g][i] >= dsh;
                    n_rem[i] = fits[i] ? s_rem[g][i] - dsh : s_rem[g][i];
                    n_quo[i] = {s_quo[g][i][QUO_W-2:0], fits[i]};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_en) begin
                    r_v <= s_v[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d    <= s_d[g];
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_side <= s_side[g];
                end
            end

            assign s_v[g+1]    = r_v;
            assign s_d[g+1]    = r_d;
            assign s_rem[g+1]  = r_rem;
            assign s_quo[g+1]  = r_quo;
            assign s_side[g+1] = r_side;
        end
    endgenerate

    assign o_valid = s_v[QUO_W];
    assign o_quo   = s_quo[QUO_W];
    assign o_side  = s_side[QUO_W];

endmodule
